>>> hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that a condition implies a consequence in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed");

// check that a condition implies a consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/mche_pkg.sv
// package: shared types, constants and the metric kind table
`timescale 1ns / 1ps
`default_nettype none
package mche_pkg;
  localparam int NUM_METRICS_DEF = 44;
  localparam int NUM_SLOTS_DEF   = 16;
  localparam int NUM_STAGES_DEF  = 13;
  localparam int NUM_BOUNDS_DEF  = 8;
  localparam int MAX_BOUNDS      = 8;
  localparam int VW              = 64;

  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_CSET  = 2'd1;
  localparam logic [1:0] MODE_GSET  = 2'd2;
  localparam logic [1:0] MODE_OBS   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_ID  = 2'd1;
  localparam logic [1:0] ST_BAD_STG = 2'd2;
  localparam logic [1:0] ST_BAD_OP  = 2'd3;

  localparam logic [63:0] COUNTER_KIND = 64'h0000_0E6C_03F0_019F;

  localparam logic [63:0] BOUND_RESET [MAX_BOUNDS] = '{
    64'd1000, 64'd2000, 64'd4000, 64'd8000,
    64'd16000, 64'd32000, 64'd64000, 64'd128000};

  // controller to datapath commands
  typedef struct packed {
    logic clr;       // clearing pass write
    logic load;      // capture input item
    logic rd;        // memory read step; the datapath does not use it
    logic wr;        // compute and write back
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_done;
  } stat_t;
endpackage
`default_nettype wire

>>> hw/rtl/mche_ram.sv
// generic ram with one write port and one read port, registered read
`timescale 1ns / 1ps
`default_nettype none
module mche_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hw/rtl/mche_ctrl.sv
// controller: clearing pass, read and write-back sequencing, handshakes
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mche_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output mche_pkg::cmd_t        cmd,
  input  wire mche_pkg::stat_t  stat
);
  localparam logic [1:0] S_CLR = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_RD = 2'd2;
  localparam logic [1:0] S_WR = 2'd3;

  logic [1:0] state, state_next;
  logic       out_valid_next;

  // a new item may enter only once the previous result has been taken
  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    state_next = state;
    out_valid_next = out_valid;
    cmd = '0;
    if (out_valid && out_ready) out_valid_next = 1'b0;
    unique case (state)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (stat.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.rd = 1'b1;
        state_next = S_WR;
      end
      S_WR: begin
        cmd.wr = 1'b1;
        out_valid_next = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `ASSERT_NEXT(a_wr_gives_result, clk, rst, cmd.wr, out_valid)
  `ASSERT_IMPLIES(a_no_accept_busy, clk, rst, out_valid, !in_ready)
  `ASSERT_NEXT(a_load_then_rd, clk, rst, cmd.load, state == S_RD)
endmodule
`default_nettype wire

>>> hw/rtl/mche_dp.sv
// datapath: validity checks, bucket search, memories and update arithmetic
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mche_dp #(
  parameter int NUM_METRICS = mche_pkg::NUM_METRICS_DEF,
  parameter int NUM_SLOTS   = mche_pkg::NUM_SLOTS_DEF,
  parameter int NUM_STAGES  = mche_pkg::NUM_STAGES_DEF,
  parameter int NUM_BOUNDS  = mche_pkg::NUM_BOUNDS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire mche_pkg::cmd_t        cmd,
  output mche_pkg::stat_t            stat,
  input  wire logic [1:0]            in_mode,
  input  wire logic [5:0]            in_metric,
  input  wire logic [4:0]            in_slot,
  input  wire logic [3:0]            in_stage,
  input  wire logic [63:0]           in_value,
  input  wire logic [63:0]           bounds [mche_pkg::MAX_BOUNDS],
  output logic [1:0]                 status,
  output logic [3:0]                 bucket_index,
  output logic [63:0]                new_value,
  output logic [1:0]                 item_saturations,
  output logic [63:0]                invalid_total,
  output logic [63:0]                saturation_total
);
  localparam int MDEPTH = NUM_METRICS * NUM_SLOTS;
  localparam int MAW = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
  localparam int NBK = NUM_BOUNDS + 1;
  localparam int BDEPTH = NUM_STAGES * NBK;
  localparam int BAW = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
  localparam int SAW = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
  localparam int CW = ((MDEPTH > BDEPTH) ? MAW : BAW) + 1;
  localparam logic [63:0] ONES = '1;

  // captured item
  logic [1:0]  mode;
  logic [63:0] value;
  logic [1:0]  st;
  logic [3:0]  bkt;
  logic [MAW-1:0] midx;
  logic [BAW-1:0] bidx;
  logic [SAW-1:0] sidx;
  logic [CW-1:0]  clr_cnt;

  logic [1:0]  st_c;
  logic [3:0]  bkt_c;
  logic        kind;

  always_comb begin
    kind = mche_pkg::COUNTER_KIND[in_metric];
    bkt_c = 4'(NUM_BOUNDS);
    for (int i = NUM_BOUNDS - 1; i >= 0; i--) begin
      if (bounds[i] >= in_value) bkt_c = 4'(i);
    end
    if (32'(in_metric) >= NUM_METRICS || 32'(in_slot) >= NUM_SLOTS) st_c = mche_pkg::ST_BAD_ID;
    else if (in_mode == mche_pkg::MODE_OBS)
      st_c = (32'(in_stage) >= NUM_STAGES) ? mche_pkg::ST_BAD_STG : mche_pkg::ST_OK;
    else if (kind ? (in_mode == mche_pkg::MODE_GSET) : (in_mode != mche_pkg::MODE_GSET))
      st_c = mche_pkg::ST_BAD_OP;
    else st_c = mche_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode <= in_mode;
      value <= in_value;
      st <= st_c;
      bkt <= bkt_c;
      midx <= MAW'(32'(in_metric) * NUM_SLOTS + 32'(in_slot));
      bidx <= BAW'(32'(in_stage) * NBK + 32'(bkt_c));
      sidx <= SAW'(in_stage);
    end
  end

  // memories
  logic [63:0] mv_r, bc_r, sc_r, ss_r, sm_r;
  logic [63:0] mv_w, bc_w, sc_w, ss_w, sm_w;
  logic mwe, hwe;
  logic [MAW-1:0] mwa;
  logic [BAW-1:0] bwa;
  logic [SAW-1:0] swa;

  mche_ram #(.WIDTH(64), .DEPTH(MDEPTH)) u_mv (.clk, .we(mwe), .waddr(mwa),
    .wdata(mv_w), .raddr(midx), .rdata(mv_r));
  mche_ram #(.WIDTH(64), .DEPTH(BDEPTH)) u_bc (.clk, .we(hwe), .waddr(bwa),
    .wdata(bc_w), .raddr(bidx), .rdata(bc_r));
  mche_ram #(.WIDTH(64), .DEPTH(NUM_STAGES)) u_sc (.clk, .we(hwe), .waddr(swa),
    .wdata(sc_w), .raddr(sidx), .rdata(sc_r));
  mche_ram #(.WIDTH(64), .DEPTH(NUM_STAGES)) u_ss (.clk, .we(hwe), .waddr(swa),
    .wdata(ss_w), .raddr(sidx), .rdata(ss_r));
  mche_ram #(.WIDTH(64), .DEPTH(NUM_STAGES)) u_sm (.clk, .we(hwe), .waddr(swa),
    .wdata(sm_w), .raddr(sidx), .rdata(sm_r));

  logic [64:0] mv_sum, bc_sum, sc_sum, ss_sum, inv_sum;
  logic [1:0]  sats;
  logic [63:0] inv_next, sat_next, nv;

  assign mv_sum  = {1'b0, mv_r} + {1'b0, value};
  assign bc_sum  = {1'b0, bc_r} + 65'd1;
  assign sc_sum  = {1'b0, sc_r} + 65'd1;
  assign ss_sum  = {1'b0, ss_r} + {1'b0, value};
  assign inv_sum = {1'b0, invalid_total} + 65'd1;

  always_comb begin
    mwe = 1'b0;
    hwe = 1'b0;
    mwa = midx;
    bwa = bidx;
    swa = sidx;
    mv_w = '0;
    bc_w = '0;
    sc_w = '0;
    ss_w = '0;
    sm_w = '0;
    sats = '0;
    nv = '0;
    inv_next = invalid_total;
    if (cmd.clr) begin
      mwa = clr_cnt[MAW-1:0];
      bwa = clr_cnt[BAW-1:0];
      swa = clr_cnt[SAW-1:0];
      mwe = 32'(clr_cnt) < MDEPTH;
      hwe = 32'(clr_cnt) < BDEPTH;
    end else if (cmd.wr) begin
      if (st != mche_pkg::ST_OK) begin
        inv_next = inv_sum[64] ? ONES : inv_sum[63:0];
        sats = {1'b0, inv_sum[64]};
      end else if (mode == mche_pkg::MODE_OBS) begin
        hwe = 1'b1;
        bc_w = bc_sum[64] ? ONES : bc_sum[63:0];
        sc_w = sc_sum[64] ? ONES : sc_sum[63:0];
        ss_w = ss_sum[64] ? ONES : ss_sum[63:0];
        sm_w = (value > sm_r) ? value : sm_r;
        sats = 2'({1'b0, bc_sum[64]} + {1'b0, sc_sum[64]} + {1'b0, ss_sum[64]});
        nv = bc_w;
      end else begin
        mwe = 1'b1;
        if (mode == mche_pkg::MODE_ADD) begin
          mv_w = mv_sum[64] ? ONES : mv_sum[63:0];
          sats = {1'b0, mv_sum[64]};
        end else mv_w = value;
        nv = mv_w;
      end
    end
    // saturation total: add per-item events, stop at maximum
    if ({62'd0, sats} > ONES - saturation_total) sat_next = ONES;
    else sat_next = saturation_total + {62'd0, sats};
  end

  assign stat.clr_done = cmd.clr && (32'(clr_cnt) >= MDEPTH - 1)
                         && (32'(clr_cnt) >= BDEPTH - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      invalid_total <= '0;
      saturation_total <= '0;
    end else begin
      if (cmd.clr) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.wr) begin
        invalid_total <= inv_next;
        saturation_total <= sat_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      status <= st;
      bucket_index <= (st == mche_pkg::ST_OK && mode == mche_pkg::MODE_OBS) ? bkt : 4'd0;
      new_value <= nv;
      item_saturations <= sats;
    end
  end

  `ASSERT_IMPLIES(a_no_write_on_reject, clk, rst, cmd.wr && st != mche_pkg::ST_OK,
    !mwe && !hwe)
  `ASSERT_NEXT(a_inv_monotone, clk, rst, cmd.wr,
    invalid_total >= $past(invalid_total))
  `ASSERT_IMPLIES(a_bucket_range, clk, rst, cmd.wr, 32'(bkt) <= NUM_BOUNDS)
endmodule
`default_nettype wire

>>> hw/rtl/metric_counter_histogram_engine.sv
// top level: statistics counters and latency histogram engine
// channel   dir  handshake              payload
// s_axis    in   s_axis_tvalid/tready   tdata: value, metric, slot, stage; tuser: mode
// m_axis    out  m_axis_tvalid/tready   tdata: new_value, invalid, saturation, etc
// cfg       in   cfg_valid/cfg_ready    cfg_index, cfg_data (bound registers)
// each item goes from input transfer to result valid through these steps:
// capture, memory read, read-modify-write back
// one item in flight; the next input transfer comes at the earliest in the
// cycle after the result transfer
// after reset a clearing pass zeroes every address of the memories;
// no item accepted meanwhile
// result held in an output register while the sink stalls
`timescale 1ns / 1ps
`default_nettype none
module metric_counter_histogram_engine #(
  parameter int NUM_METRICS = mche_pkg::NUM_METRICS_DEF,
  parameter int NUM_SLOTS   = mche_pkg::NUM_SLOTS_DEF,
  parameter int NUM_STAGES  = mche_pkg::NUM_STAGES_DEF,
  parameter int NUM_BOUNDS  = mche_pkg::NUM_BOUNDS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // metric_id[5:0], slot_id[10:6], stage_id[14:11], value[78:15], pad to 80
  input  wire logic [79:0]  s_axis_tdata,
  // mode[1:0]
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // bucket_index[3:0], new_value[67:4], item_saturations[69:68],
  // invalid_total[133:70], saturation_total[197:134], pad to 200
  output logic [199:0]      m_axis_tdata,
  // status[1:0]
  output logic [1:0]        m_axis_tuser,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [63:0]  cfg_data
);
  mche_pkg::cmd_t  cmd;
  mche_pkg::stat_t stat;
  logic [63:0] bounds [mche_pkg::MAX_BOUNDS];
  logic [3:0]  bucket_index;
  logic [63:0] new_value, invalid_total, saturation_total;
  logic [1:0]  item_saturations;

  assign cfg_ready = 1'b1;

  // bound registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mche_pkg::MAX_BOUNDS; i++) bounds[i] <= mche_pkg::BOUND_RESET[i];
    end else if (cfg_valid) begin
      bounds[cfg_index] <= cfg_data;
    end
  end

  mche_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .cmd, .stat);

  mche_dp #(.NUM_METRICS(NUM_METRICS), .NUM_SLOTS(NUM_SLOTS),
    .NUM_STAGES(NUM_STAGES), .NUM_BOUNDS(NUM_BOUNDS)) u_dp (
    .clk, .rst, .cmd, .stat,
    .in_mode(s_axis_tuser), .in_metric(s_axis_tdata[5:0]),
    .in_slot(s_axis_tdata[10:6]), .in_stage(s_axis_tdata[14:11]),
    .in_value(s_axis_tdata[78:15]), .bounds,
    .status(m_axis_tuser), .bucket_index, .new_value, .item_saturations,
    .invalid_total, .saturation_total);

  assign m_axis_tdata = {2'b00, saturation_total, invalid_total, item_saturations,
                         new_value, bucket_index};
endmodule
`default_nettype wire
